FILE: hdl/tia_pkg.sv
// ----------------------------------------------------------------------------
// Turbo interleaver address package
// Shared widths, constants and small lookup functions for the address pipe.
// ----------------------------------------------------------------------------
package tia_pkg;

  localparam int POS_W       = 14;
  localparam int MULT_W      = 3;
  localparam int BASE_OCTETS = 223;
  localparam int PRIME_W     = 6;

  localparam logic [4:0] OFFSET_M = 5'd21;

  typedef struct packed {
    logic       oor;
    logic       m;
    logic [1:0] t;
  } ctl_t;

  // t = (19*i + 1) mod 4
  function automatic logic [1:0] t_of_i(input logic [1:0] i);
    logic [1:0] t;
    case (i)
      2'd0:    t = 2'd1;
      2'd1:    t = 2'd0;
      2'd2:    t = 2'd3;
      2'd3:    t = 2'd2;
      default: t = 2'd0;
    endcase
    return t;
  endfunction

  // Only the first four primes are reachable since t < 4.
  function automatic logic [PRIME_W-1:0] prime_of(input logic [1:0] q);
    logic [PRIME_W-1:0] p;
    case (q)
      2'd0:    p = 6'd31;
      2'd1:    p = 6'd37;
      2'd2:    p = 6'd43;
      2'd3:    p = 6'd47;
      default: p = 6'd31;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/turbo_interleaver_address.sv
// ----------------------------------------------------------------------------
// Turbo interleaver address generator
// Maps a bit position to its interleaved position, k1 = 8, k2 = 223 * mult.
//
//   channel | ports                                      | direction
//   in      | in_valid, in_ready, in_bit_position        | word in
//   out     | out_valid, out_ready, out_permuted_position,| word out
//           | out_out_of_range                           |
//   cfg     | cfg_wr_en, cfg_wr_data                     | register write
//
// One word per cycle while the output is not stalled, through five pipe stages
// (range split, multiply, three stages of two restoring mod-k2 steps each).
// A stalled output freezes every stage together; in_ready is high when out_ready
// is high or the output is empty. Synchronous active-low reset clears the valid
// bits and sets the multiplier to 1.
// ----------------------------------------------------------------------------
module turbo_interleaver_address
  import tia_pkg::*;
#(
  parameter int MAX_MULTIPLIER = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [MULT_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [POS_W-1:0]  in_bit_position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  out_permuted_position,
  output logic              out_out_of_range
);

  localparam int K2_MAX = BASE_OCTETS * MAX_MULTIPLIER;
  localparam int K2_W   = $clog2(K2_MAX + 1);
  localparam int LEN_W  = K2_W + 3;
  localparam int CMP_W  = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam int X_W    = $clog2(48 * K2_MAX);
  localparam logic [MULT_W:0] MAX_M = (MULT_W + 1)'(MAX_MULTIPLIER);

  function automatic logic [X_W-1:0] mod_step(input logic [X_W-1:0] x,
                                               input logic [X_W-1:0] d);
    return (x >= d) ? x - d : x;
  endfunction

  // configuration
  logic [MULT_W-1:0] mult_eff;
  logic [K2_W-1:0]   k2_r, k2_nxt;
  logic [K2_W:0]     k2x2_r;
  logic [K2_W+1:0]   k2x3_r;
  logic [LEN_W-1:0]  len_r;

  always_comb begin
    if (cfg_wr_data == '0) begin
      mult_eff = MULT_W'(1);
    end else if ({1'b0, cfg_wr_data} > MAX_M) begin
      mult_eff = MAX_M[MULT_W-1:0];
    end else begin
      mult_eff = cfg_wr_data;
    end
    k2_nxt = K2_W'(BASE_OCTETS * int'(mult_eff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k2_r   <= K2_W'(BASE_OCTETS);
      k2x2_r <= (K2_W + 1)'(2 * BASE_OCTETS);
      k2x3_r <= (K2_W + 2)'(3 * BASE_OCTETS);
      len_r  <= LEN_W'(8 * BASE_OCTETS);
    end else if (cfg_wr_en) begin
      k2_r   <= k2_nxt;
      k2x2_r <= {k2_nxt, 1'b0};
      k2x3_r <= {1'b0, k2_nxt, 1'b0} + (K2_W + 2)'(k2_nxt);
      len_r  <= {k2_nxt, 3'b000};
    end
  end

  // pipe control
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: range check, i, j, t
  logic [CMP_W-1:0] h_ext, sel;
  logic             ge1, ge2, ge3;
  logic [1:0]       i_val;
  ctl_t             s1_ctl_nxt;
  logic [K2_W-1:0]  s1_j_nxt;

  always_comb begin
    h_ext = CMP_W'(in_bit_position[POS_W-1:1]);
    ge1   = h_ext >= CMP_W'(k2_r);
    ge2   = h_ext >= CMP_W'(k2x2_r);
    ge3   = h_ext >= CMP_W'(k2x3_r);
    if (ge3) begin
      i_val = 2'd3;
      sel   = CMP_W'(k2x3_r);
    end else if (ge2) begin
      i_val = 2'd2;
      sel   = CMP_W'(k2x2_r);
    end else if (ge1) begin
      i_val = 2'd1;
      sel   = CMP_W'(k2_r);
    end else begin
      i_val = 2'd0;
      sel   = '0;
    end
    s1_ctl_nxt.oor = CMP_W'(in_bit_position) >= CMP_W'(len_r);
    s1_ctl_nxt.m   = in_bit_position[0];
    s1_ctl_nxt.t   = t_of_i(i_val);
    s1_j_nxt       = K2_W'(h_ext - sel);
  end

  logic            s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  ctl_t            s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r;
  logic [K2_W-1:0] s1_j_r;
  logic [X_W-1:0]  s2_x_r, s3_x_r, s4_x_r;
  logic [X_W-1:0]  s2_x_nxt, s3_x_nxt, s4_x_nxt, c_full;
  logic [X_W-1:0]  k2_ext;

  assign k2_ext = X_W'(k2_r);

  // stage 2: p[q]*j + 21*m
  assign s2_x_nxt = X_W'(s1_j_r) * X_W'(prime_of(s1_ctl_r.t))
                  + (s1_ctl_r.m ? X_W'(OFFSET_M) : '0);

  // stages 3 to 5: restoring mod k2, two quotient bits a stage
  assign s3_x_nxt = mod_step(mod_step(s2_x_r, k2_ext << 5), k2_ext << 4);
  assign s4_x_nxt = mod_step(mod_step(s3_x_r, k2_ext << 3), k2_ext << 2);
  assign c_full   = mod_step(mod_step(s4_x_r, k2_ext << 1), k2_ext);

  logic             out_valid_r;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_oor_r;

  // 2*(t + 4c + 1) - m - 1 = {c, t, ~m}
  assign out_pos_nxt = s4_ctl_r.oor ? '0
                     : POS_W'({c_full[K2_W-1:0], s4_ctl_r.t, ~s4_ctl_r.m});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      out_valid_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r  <= s1_ctl_nxt;
      s1_j_r    <= s1_j_nxt;
      s2_ctl_r  <= s1_ctl_r;
      s2_x_r    <= s2_x_nxt;
      s3_ctl_r  <= s2_ctl_r;
      s3_x_r    <= s3_x_nxt;
      s4_ctl_r  <= s3_ctl_r;
      s4_x_r    <= s4_x_nxt;
      out_pos_r <= out_pos_nxt;
      out_oor_r <= s4_ctl_r.oor;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_permuted_position = out_pos_r;
  assign out_out_of_range      = out_oor_r;

endmodule

FILE: hdl/tia_checker.sv
// ----------------------------------------------------------------------------
// Turbo interleaver address checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tia_checker
  import tia_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [POS_W-1:0]  out_permuted_position,
  input logic              out_out_of_range
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_permuted_position)
                                && $stable(out_out_of_range))
    else $error("output word changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_permuted_position == '0)
    else $error("out of range word carries nonzero position");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind turbo_interleaver_address tia_checker u_tia_checker (.*);

FILE: test/turbo_interleaver_address_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Turbo interleaver address testbench
// Sends bit positions through the valid/ready input and compares every
// returned word against a typed value or the in-bench permutation model,
// across several multiplier settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module turbo_interleaver_address_tb;
  import tia_pkg::*;

  localparam int          MAX_MULT = 5;
  localparam int unsigned STEP_I   = 19;
  localparam int unsigned K1_HALF  = 4;
  localparam int          N_PHASES = 7;
  localparam int          N_WORDS  = 147;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             oor;
  } addr_result_t;

  typedef enum logic { ROW_CFG, ROW_WORD } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [MULT_W-1:0] mult;
    logic [POS_W-1:0]  pos;
    bit                typed;
    addr_result_t      want;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [MULT_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [POS_W-1:0]  in_bit_position;
  logic              out_valid;
  logic              out_ready;
  logic [POS_W-1:0]  out_permuted_position;
  logic              out_out_of_range;

  logic [MULT_W-1:0] mult_mirror;
  addr_result_t      expected_q[$];
  stim_row_t         dir_rows[$];
  int                mismatches = 0;
  bit                in_quiet   = 1'b0;
  bit                out_quiet  = 1'b0;

  turbo_interleaver_address #(
    .MAX_MULTIPLIER(MAX_MULT)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_bit_position      (in_bit_position),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_permuted_position(out_permuted_position),
    .out_out_of_range     (out_out_of_range)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned half_block(input logic [MULT_W-1:0] mult_reg);
    int unsigned mult;
    mult = mult_reg;
    if (mult == 0) mult = 1;
    if (mult > MAX_MULT) mult = MAX_MULT;
    return BASE_OCTETS * mult;
  endfunction

  function automatic addr_result_t interleave_addr(input logic [MULT_W-1:0] mult_reg,
                                                   input logic [POS_W-1:0] pos);
    int unsigned k2, m, i, j, t, p, c;
    addr_result_t r;
    k2 = half_block(mult_reg);
    r.pos = '0;
    r.oor = 1'b1;
    if (pos >= 8 * k2) return r;
    m = pos[0];
    i = pos / (2 * k2);
    j = (pos >> 1) - i * k2;
    t = (STEP_I * i + 1) % K1_HALF;
    case (t & 7)
      0: p = 31;
      1: p = 37;
      2: p = 43;
      3: p = 47;
      4: p = 53;
      5: p = 59;
      6: p = 61;
      default: p = 67;
    endcase
    c = (p * j + OFFSET_M * m) % k2;
    r.pos = POS_W'(2 * (t + K1_HALF * c + 1) - m - 1);
    r.oor = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mult_mirror <= 3'd1;
    end else if (cfg_wr_en) begin
      mult_mirror <= cfg_wr_data;
    end
  end

  // output stall generator
  initial begin
    int hold;
    int r;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_quiet) begin
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
          hold = $urandom_range(0, 6);
        end else if (r < 92) begin
          out_ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(8, 30);
        end
      end
    end
  end

  always @(posedge clk) begin
    addr_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected word: permuted_position %0d out_of_range %0b",
               out_permuted_position, out_out_of_range);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_permuted_position !== want.pos) begin
          $error("permuted_position: expected %0d, got %0d", want.pos, out_permuted_position);
          mismatches++;
        end
        if (out_out_of_range !== want.oor) begin
          $error("out_of_range: expected %0b, got %0b", want.oor, out_out_of_range);
          mismatches++;
        end
      end
    end
  end

  task automatic send_word(input logic [POS_W-1:0] pos, input bit typed,
                           input addr_result_t want);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (in_quiet || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_bit_position <= pos;
    do @(posedge clk); while (!in_ready);
    if (typed) expected_q.push_back(want);
    else expected_q.push_back(interleave_addr(mult_mirror, pos));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_mult(input logic [MULT_W-1:0] mult);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mult;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic void add_cfg(input logic [MULT_W-1:0] mult);
    stim_row_t row;
    row = '{ROW_CFG, mult, '0, 1'b0, '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_word(input logic [POS_W-1:0] pos, input bit typed,
                                   input logic [POS_W-1:0] want_pos, input logic want_oor);
    stim_row_t row;
    row = '{ROW_WORD, '0, pos, typed, '{want_pos, want_oor}};
    dir_rows.push_back(row);
  endfunction

  initial begin
    #5_000_000;
    $display("turbo_interleaver_address_tb failed");
    $finish;
  end

  initial begin
    int unsigned       len;
    int unsigned       k2;
    int                r;
    logic [POS_W-1:0]  pos;
    logic [MULT_W-1:0] mult;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_bit_position = '0;

    // reset multiplier of 1
    add_word(14'd0,     1'b1, 14'd3, 1'b0);
    add_word(14'd1,     1'b0, '0,    1'b0);
    add_word(14'd446,   1'b0, '0,    1'b0);
    add_word(14'd892,   1'b0, '0,    1'b0);
    add_word(14'd1338,  1'b0, '0,    1'b0);
    add_word(14'd1783,  1'b0, '0,    1'b0);
    add_word(14'd1784,  1'b1, 14'd0, 1'b1);
    add_word(14'd16383, 1'b1, 14'd0, 1'b1);
    // zero multiplier behaves as one
    add_cfg(3'd0);
    add_word(14'd1783,  1'b0, '0,    1'b0);
    add_word(14'd1784,  1'b1, 14'd0, 1'b1);
    add_cfg(3'd5);
    add_word(14'd0,     1'b1, 14'd3, 1'b0);
    add_word(14'd8918,  1'b0, '0,    1'b0);
    add_word(14'd8919,  1'b0, '0,    1'b0);
    add_word(14'd8920,  1'b1, 14'd0, 1'b1);
    add_word(14'd16383, 1'b1, 14'd0, 1'b1);
    // multipliers above the maximum clamp
    add_cfg(3'd7);
    add_word(14'd8919,  1'b0, '0,    1'b0);
    add_word(14'd8920,  1'b1, 14'd0, 1'b1);
    add_cfg(3'd6);
    add_word(14'd4461,  1'b0, '0,    1'b0);
    add_word(14'd8920,  1'b1, 14'd0, 1'b1);
    add_cfg(3'd2);
    add_word(14'd3567,  1'b0, '0,    1'b0);
    add_word(14'd3568,  1'b1, 14'd0, 1'b1);
    add_cfg(3'd3);
    add_word(14'd5351,  1'b0, '0,    1'b0);
    add_cfg(3'd4);
    add_word(14'd7135,  1'b0, '0,    1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG) write_mult(dir_rows[n].mult);
      else send_word(dir_rows[n].pos, dir_rows[n].typed, dir_rows[n].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 0) mult = 3'd5;
      else if (ph == 1) mult = 3'd1;
      else mult = MULT_W'($urandom_range(0, 7));
      write_mult(mult);
      in_quiet  = (ph == 3);
      out_quiet = (ph == 4);
      k2  = half_block(mult_mirror);
      len = 8 * k2;
      for (int n = 0; n < N_WORDS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 80) pos = POS_W'($urandom_range(0, len - 1));
        else if (r < 88) pos = POS_W'($urandom_range(len, 2 ** POS_W - 1));
        else if (r < 92) pos = POS_W'(len - 1);
        else if (r < 94) pos = POS_W'(len);
        else if (r < 97) pos = POS_W'(2 * k2 * $urandom_range(0, 3) + $urandom_range(0, 1));
        else pos = $urandom_range(0, 1) ? '1 : '0;
        // hold off the sender until the pipe is empty
        if (n == N_WORDS / 2 && ph == 2) drain();
        send_word(pos, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("turbo_interleaver_address_tb passed");
    end else begin
      $display("turbo_interleaver_address_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/tia_pkg.sv
hdl/turbo_interleaver_address.sv
hdl/tia_checker.sv
test/turbo_interleaver_address_tb.sv
